// ===== sv/csrspmv_pkg.sv =====
// Package for the compressed-row sparse matrix times vector block.
// Holds command codes, field widths, bus widths and register indexes.
// No dependencies; imported by the top level and by its checker.
package csrspmv_pkg;

  localparam int unsigned DEFAULT_VECTOR_DEPTH = 1024;

  // Field widths of one input transaction and of one result transaction.
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned INDEX_W   = 10;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned ROW_W     = 10;
  localparam int unsigned SUM_W     = 64;
  localparam int unsigned LENGTH_W  = 11;

  // Widened index and length, wide enough for the largest supported depth.
  localparam int unsigned EXT_W     = 17;

  // Stream bus widths, padded to whole bytes.
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 80;

  // Register bus.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [LENGTH_W-1:0] VECTOR_LENGTH_RESET = 11'd1024;

  // Register indexes (paddr divided by four).
  localparam logic REG_VECTOR_LENGTH = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_NONZERO = 2'd1,
    CMD_CLOSE   = 2'd2
  } cmd_t;

endpackage

// ===== sv/csr_sparse_matrix_vector_multiply.sv =====
// Top level of the compressed-row sparse matrix times dense vector block.
// Holds the vector memory, the multiply-accumulate pipeline and the register port.
// Depends on csrspmv_pkg.
//
// Usage: the input stream carries three kinds of transactions, selected by in_tuser.
// A load writes one element of the dense vector into the internal vector memory.
// A nonzero carries a matrix value and its column; in_tlast marks the last
// nonzero of a row. A close ends the current row, giving a zero sum for an empty row.
// Each finished row leaves on the output stream as one transaction holding the row
// number, the saturated Q16.48 row sum and a column error flag. The vector length
// register at byte address 0 sets the number of rows and of vector elements in use.
// The user writes it on the APB-style port only while idle; the block does not check.
//
// Throughput is one input transaction per cycle while in_tready is high. The
// transaction that ends a row reaches the output through the registered vector
// memory read, the registered 32 by 32 multiply and the accumulate into the
// output register, where its result can be taken.
// A load is visible to a nonzero accepted in the very next cycle.
// When the receiver stalls, the result waits in the output register while
// loads and nonzeros keep flowing; only a second row end backs up, and then
// in_tready drops. Synchronous reset clears the accumulator, the error flag,
// the row number and all valid bits and sets the vector length to 1024; the
// vector memory is not cleared and must be loaded before use.
module csr_sparse_matrix_vector_multiply #(
  parameter int unsigned MAX_VECTOR_DEPTH = csrspmv_pkg::DEFAULT_VECTOR_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input stream.
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [9:0] index, [41:10] value, [47:42] zero.
  input  logic [csrspmv_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [1:0] command.
  input  logic [csrspmv_pkg::CMD_W-1:0]         in_tuser,
  input  logic                                  in_tlast,
  // Result stream.
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [9:0] row_number, [73:10] row_sum, [79:74] zero.
  output logic [csrspmv_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [0] column_error.
  output logic                                  out_tuser,
  // Register port.
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [csrspmv_pkg::PADDR_W-1:0]       paddr,
  input  logic [csrspmv_pkg::PDATA_W-1:0]       pwdata,
  output logic [csrspmv_pkg::PDATA_W-1:0]       prdata,
  output logic                                  pready
);
  import csrspmv_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MAX_VECTOR_DEPTH);
  localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(MAX_VECTOR_DEPTH);
  localparam logic [EXT_W-1:0] ONE_EXT   = EXT_W'(1);

  typedef struct packed {
    logic add;   // in-range nonzero: add the product
    logic err;   // out-of-range nonzero: flag the row
    logic emit;  // this transaction ends the row
  } ctrl_t;

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------
  logic [LENGTH_W-1:0] vector_length_r;
  logic                cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vector_length_r <= VECTOR_LENGTH_RESET;
    end else if (cfg_write && (paddr[2] == REG_VECTOR_LENGTH)) begin
      vector_length_r <= pwdata[LENGTH_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_VECTOR_LENGTH) begin
      prdata = PDATA_W'(vector_length_r);
    end
  end

  // Effective length: zero counts as one, anything above the memory depth is clamped.
  logic [EXT_W-1:0] length_ext;
  logic [EXT_W-1:0] eff_length;

  assign length_ext = EXT_W'(vector_length_r);

  always_comb begin
    priority if (length_ext == '0) begin
      eff_length = ONE_EXT;
    end else if (length_ext > DEPTH_EXT) begin
      eff_length = DEPTH_EXT;
    end else begin
      eff_length = length_ext;
    end
  end

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  logic                       in_accept;
  logic [INDEX_W-1:0]         in_index;
  logic signed [VALUE_W-1:0]  in_value;
  logic [EXT_W-1:0]           index_ext;
  logic [ADDR_W-1:0]          mem_addr;
  logic                       in_store;
  logic                       in_length;
  logic                       is_load;
  logic                       is_nonzero;
  logic                       is_close;
  ctrl_t                      in_ctrl;

  assign in_accept  = in_tvalid && in_tready;
  assign in_index   = in_tdata[INDEX_W-1:0];
  assign in_value   = in_tdata[INDEX_W +: VALUE_W];
  assign index_ext  = EXT_W'(in_index);
  assign mem_addr   = index_ext[ADDR_W-1:0];
  assign in_store   = index_ext < DEPTH_EXT;
  assign in_length  = index_ext < eff_length;

  always_comb begin
    is_load    = 1'b0;
    is_nonzero = 1'b0;
    is_close   = 1'b0;
    unique case (in_tuser)
      CMD_LOAD:    is_load    = 1'b1;
      CMD_NONZERO: is_nonzero = 1'b1;
      CMD_CLOSE:   is_close   = 1'b1;
      default:     ;  // unused code, dropped
    endcase
  end

  assign in_ctrl.add  = is_nonzero && in_length;
  assign in_ctrl.err  = is_nonzero && !in_length;
  assign in_ctrl.emit = is_close || (is_nonzero && in_tlast);

  // ---------------------------------------------------------------------------
  // Vector memory: written by loads, read by in-range nonzeros, read data registered
  // ---------------------------------------------------------------------------
  logic [VALUE_W-1:0]        vector_mem [MAX_VECTOR_DEPTH];
  logic signed [VALUE_W-1:0] mem_rdata_r;

  always_ff @(posedge clk) begin
    if (in_accept && is_load && in_store) begin
      vector_mem[mem_addr] <= in_value;
    end
    if (in_accept && in_ctrl.add) begin
      mem_rdata_r <= vector_mem[mem_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshakes
  // ---------------------------------------------------------------------------
  logic  s1_valid_r;
  ctrl_t s1_ctrl_r;
  logic signed [VALUE_W-1:0] s1_value_r;

  logic  s2_valid_r;
  ctrl_t s2_ctrl_r;
  logic signed [SUM_W-1:0] s2_prod_r;

  logic out_valid_r;
  logic out_free;
  logic s2_go;
  logic s2_free;
  logic s1_free;

  assign out_free  = !out_valid_r || out_tready;
  assign s2_go     = s2_valid_r && (!s2_ctrl_r.emit || out_free);
  assign s2_free   = !s2_valid_r || s2_go;
  assign s1_free   = !s1_valid_r || s2_free;
  assign in_tready = s1_free;

  // Stage 1: control and matrix value, alongside the memory read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= in_accept && (is_nonzero || is_close);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_ctrl_r  <= in_ctrl;
      s1_value_r <= in_value;
    end
  end

  // Stage 2: registered product.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_free) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_ctrl_r <= s1_ctrl_r;
      s2_prod_r <= s1_value_r * mem_rdata_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: saturating accumulate, row bookkeeping, result register
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] acc_r;
  logic signed [SUM_W-1:0] acc_nxt;
  logic signed [SUM_W-1:0] acc_sum;
  logic                    acc_ovf;
  logic                    row_err_r;
  logic                    row_err_nxt;
  logic [ROW_W-1:0]        row_r;
  logic [ROW_W-1:0]        row_inc;
  logic [ROW_W-1:0]        row_nxt;
  logic [SUM_W-1:0]        out_sum_r;
  logic [ROW_W-1:0]        out_row_r;
  logic                    out_err_r;

  assign acc_sum = acc_r + s2_prod_r;
  // Overflow when both addends share a sign and the sum does not.
  assign acc_ovf = (acc_r[SUM_W-1] == s2_prod_r[SUM_W-1]) &&
                   (acc_sum[SUM_W-1] != acc_r[SUM_W-1]);

  always_comb begin
    acc_nxt = acc_r;
    if (s2_ctrl_r.add) begin
      if (acc_ovf) begin
        acc_nxt = acc_r[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
        acc_nxt = acc_sum;
      end
    end
  end

  assign row_err_nxt = row_err_r || s2_ctrl_r.err;

  // Row numbers wrap at the effective length and at the 10-bit limit.
  assign row_inc = row_r + ROW_W'(1);
  assign row_nxt = (EXT_W'(row_inc) >= eff_length) ? '0 : row_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      row_err_r <= 1'b0;
      row_r     <= '0;
    end else if (s2_go) begin
      if (s2_ctrl_r.emit) begin
        acc_r     <= '0;
        row_err_r <= 1'b0;
        row_r     <= row_nxt;
      end else begin
        acc_r     <= acc_nxt;
        row_err_r <= row_err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_go && s2_ctrl_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s2_ctrl_r.emit) begin
      out_row_r <= row_r;
      out_sum_r <= acc_nxt;
      out_err_r <= row_err_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-SUM_W-ROW_W){1'b0}}, out_sum_r, out_row_r};
  assign out_tuser  = out_err_r;

endmodule

// ===== sv/csrspmv_checker.sv =====
// Port-level checker for the sparse matrix times vector block, with its bind.
// Watches the stream ports over time.
// Depends on csrspmv_pkg and binds to csr_sparse_matrix_vector_multiply.
module csrspmv_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [csrspmv_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                                out_tuser
);
  import csrspmv_pkg::*;

  logic [ROW_W-1:0] last_row_r;
  logic             seen_row_r;
  logic             out_accept;

  assign out_accept = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_row_r <= 1'b0;
    end else if (out_accept) begin
      seen_row_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_accept) begin
      last_row_r <= out_tdata[ROW_W-1:0];
    end
  end

  // A waiting result holds still until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // With nothing waiting at the output, no stage can be backed up.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output register");

  // Rows come out in order: each row number follows the last or wraps to zero.
  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_accept && seen_row_r |->
      (out_tdata[ROW_W-1:0] == ROW_W'(last_row_r + ROW_W'(1))) ||
      (out_tdata[ROW_W-1:0] == '0))
    else $error("row number out of sequence");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind csr_sparse_matrix_vector_multiply csrspmv_checker u_csrspmv_checker (.*);

// ===== tb/sv/tb_csr_sparse_matrix_vector_multiply.sv =====
// Self-checking testbench for csr_sparse_matrix_vector_multiply.
// Drives load, nonzero and close transactions, predicts every row result and
// compares it field by field. Depends on csrspmv_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_csr_sparse_matrix_vector_multiply;
  import csrspmv_pkg::*;

  // The input bus has room for a fourth command code that the block ignores.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [PADDR_W-1:0] VECTOR_LENGTH_ADDR = PADDR_W'({REG_VECTOR_LENGTH, 2'b00});
  // Quiet cycles after the last expected row so that in-flight loads settle.
  localparam int SETTLE_CYCLES = 12;
  localparam int DEPTH = DEFAULT_VECTOR_DEPTH;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
    logic               last;
    bit                 hold;   // wait for all pending rows before sending
  } spmv_item_t;

  typedef struct {
    logic [ROW_W-1:0] row;
    logic [SUM_W-1:0] sum;
    logic             col_err;
  } row_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]       in_tuser = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [PADDR_W-1:0]     paddr = '0;
  logic [PDATA_W-1:0]     pwdata = '0;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  csr_sparse_matrix_vector_multiply dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Transactions waiting to be driven, and the rows the block still owes us.
  spmv_item_t  pending_items[$];
  row_result_t expected_rows[$];
  int n_queued = 0;
  int n_accepted = 0;
  int n_fail = 0;

  // Predictor state. It is updated at the edge where each input transaction
  // is accepted, so it always matches what the block has consumed so far.
  logic [VALUE_W-1:0]      vec_model [DEPTH];
  logic [SUM_W-1:0]        acc_model = '0;
  logic [ROW_W-1:0]        row_model = '0;
  logic                    err_model = 1'b0;
  logic [LENGTH_W-1:0]     len_model = VECTOR_LENGTH_RESET;

  // Generator state. It runs ahead of the predictor and only tracks which
  // vector entries have been loaded, so that no nonzero ever reads an entry
  // that was never written.
  bit                      gen_written [DEPTH];
  int                      usable_cols[$];
  logic [LENGTH_W-1:0]     gen_eff = VECTOR_LENGTH_RESET;

  // Out-of-range register values are clamped: zero acts as one and anything
  // above the store depth acts as the full depth.
  function automatic logic [LENGTH_W-1:0] effective_length(input logic [LENGTH_W-1:0] len);
    if (len == '0) return LENGTH_W'(1);
    if (len > LENGTH_W'(DEPTH)) return LENGTH_W'(DEPTH);
    return len;
  endfunction

  function automatic logic [SUM_W-1:0] add_saturate(input logic [SUM_W-1:0] a,
                                                    input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1])
      return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    return s[SUM_W-1:0];
  endfunction

  function automatic void finish_row();
    row_result_t r;
    logic [ROW_W-1:0] nxt;
    r.row = row_model;
    r.sum = acc_model;
    r.col_err = err_model;
    expected_rows.push_back(r);
    acc_model = '0;
    err_model = 1'b0;
    // The row number wraps at the effective length, and also at 10 bits.
    nxt = row_model + ROW_W'(1);
    if ({1'b0, nxt} >= effective_length(len_model)) nxt = '0;
    row_model = nxt;
  endfunction

  function automatic void predict_row_result(input spmv_item_t it);
    logic signed [SUM_W-1:0] lhs;
    logic signed [SUM_W-1:0] rhs;
    case (it.cmd)
      CMD_LOAD: begin
        vec_model[it.index] = it.value;
      end
      CMD_NONZERO: begin
        if ({1'b0, it.index} < effective_length(len_model)) begin
          // Q8.24 times Q8.24 is an exact Q16.48 product.
          lhs = SUM_W'($signed(it.value));
          rhs = SUM_W'($signed(vec_model[it.index]));
          acc_model = add_saturate(acc_model, lhs * rhs);
        end else begin
          err_model = 1'b1;
        end
        if (it.last) finish_row();
      end
      CMD_CLOSE: begin
        finish_row();
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Driver: bursts of random length separated by random gaps. A burst may
  // have no gap after it, so long back-to-back stretches also occur.
  // ---------------------------------------------------------------------
  spmv_item_t on_bus;
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin : drive_proc
    bit slot_free;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      slot_free = !in_tvalid;
      if (in_tvalid && in_tready) begin
        predict_row_result(on_bus);
        n_accepted++;
        slot_free = 1'b1;
      end
      if (slot_free) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() != 0 &&
                     !(pending_items[0].hold && expected_rows.size() != 0)) begin
          on_bus = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {{(IN_TDATA_W-INDEX_W-VALUE_W){1'b0}}, on_bus.value, on_bus.index};
          in_tuser  <= on_bus.cmd;
          in_tlast  <= on_bus.last;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor and receiver. Each accepted row is checked against the oldest
  // expectation. out_tready follows a mode that is picked anew at random
  // intervals: always ready, coin flip, mostly ready, or a strict one-in-16
  // pattern that forces results to back up.
  // ---------------------------------------------------------------------
  int stall_mode = 0;
  int stall_left = 0;
  int pattern_cnt = 0;

  always @(posedge clk) begin : check_proc
    row_result_t want;
    logic [ROW_W-1:0] got_row;
    logic [SUM_W-1:0] got_sum;
    if (rst_n && out_tvalid && out_tready) begin
      got_row = out_tdata[ROW_W-1:0];
      got_sum = out_tdata[ROW_W +: SUM_W];
      if (expected_rows.size() == 0) begin
        $display("%0t: row result with nothing pending: row %0d sum %h error %b",
                 $time, got_row, got_sum, out_tuser);
        n_fail++;
      end else begin
        want = expected_rows.pop_front();
        if (got_row !== want.row) begin
          $display("%0t: row_number expected %0d actual %0d", $time, want.row, got_row);
          n_fail++;
        end
        if (got_sum !== want.sum) begin
          $display("%0t: row_sum of row %0d expected %h actual %h",
                   $time, want.row, want.sum, got_sum);
          n_fail++;
        end
        if (out_tuser !== want.col_err) begin
          $display("%0t: column_error of row %0d expected %b actual %b",
                   $time, want.row, want.col_err, out_tuser);
          n_fail++;
        end
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(50, 300);
    end else begin
      stall_left--;
    end
    pattern_cnt++;
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 99) < 85);
      default: out_tready <= (pattern_cnt % 16 == 0);
    endcase
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------
  task automatic add_item(input logic [CMD_W-1:0] cmd, input int index,
                          input logic [VALUE_W-1:0] value, input logic last,
                          input bit hold = 1'b0);
    spmv_item_t it;
    it.cmd = cmd;
    it.index = INDEX_W'(index);
    it.value = value;
    it.last = last;
    it.hold = hold;
    if (cmd == CMD_LOAD) begin
      if (!gen_written[index] && index < int'(gen_eff)) usable_cols.push_back(index);
      gen_written[index] = 1'b1;
    end
    pending_items.push_back(it);
    n_queued++;
  endtask

  // Weighted toward the Q8.24 extremes so that saturation happens often.
  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 11))
      0: return {1'b1, {(VALUE_W-1){1'b0}}};
      1: return {1'b0, {(VALUE_W-1){1'b1}}};
      2: return {VALUE_W{1'b1}};
      3: return VALUE_W'(1 << 24);
      default: return $urandom();
    endcase
  endfunction

  // Mostly a loaded column inside the vector; sometimes a column past its end.
  function automatic int pick_column();
    if (gen_eff < LENGTH_W'(DEPTH) && $urandom_range(0, 99) < 8)
      return $urandom_range(int'(gen_eff), DEPTH - 1);
    return usable_cols[$urandom_range(0, usable_cols.size() - 1)];
  endfunction

  // Well-formed rows with random content, plus some noise: ignored commands,
  // closes that cut a row short, stray loads, and now and then a transaction
  // that holds until every pending row has come back.
  task automatic add_random_rows(input int n_rows, input bit short_rows);
    int pick;
    int len;
    bit hold;
    for (int r = 0; r < n_rows; r++) begin
      if ($urandom_range(0, 99) < 6)
        add_item(CMD_LOAD, $urandom_range(0, DEPTH - 1), rand_value(),
                 1'($urandom_range(0, 1)));
      hold = ($urandom_range(0, 199) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        add_item(CMD_UNUSED, $urandom_range(0, DEPTH - 1), rand_value(),
                 1'($urandom_range(0, 1)), hold);
      end else if (pick < 20) begin
        add_item(CMD_CLOSE, $urandom_range(0, DEPTH - 1), rand_value(),
                 1'($urandom_range(0, 1)), hold);
      end else if (pick < 25) begin
        len = $urandom_range(1, 3);
        for (int k = 0; k < len; k++)
          add_item(CMD_NONZERO, pick_column(), rand_value(), 1'b0, hold && k == 0);
        add_item(CMD_CLOSE, $urandom_range(0, DEPTH - 1), rand_value(),
                 1'($urandom_range(0, 1)));
      end else begin
        if (short_rows) len = (pick < 95) ? 1 : 2;
        else len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++)
          add_item(CMD_NONZERO, pick_column(), rand_value(), k == len - 1, hold && k == 0);
      end
    end
  endtask

  // Returns once every queued transaction is in and every row is out.
  task automatic wait_idle();
    do @(posedge clk);
    while (n_accepted != n_queued || expected_rows.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the length register, then read it back.
  task automatic write_vector_length(input logic [LENGTH_W-1:0] len);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= VECTOR_LENGTH_ADDR;
    pwdata  <= PDATA_W'(len);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // The write lands at this edge; the read setup follows directly.
    len_model = len;
    gen_eff = effective_length(len);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== PDATA_W'(len)) begin
      $display("%0t: vector_length read expected %h actual %h", $time, PDATA_W'(len), prdata);
      n_fail++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Rebuild the usable column list for the new length and load a few more
  // entries so that every phase has columns to work with.
  task automatic start_random_phase(input logic [LENGTH_W-1:0] len);
    int n_loads;
    wait_idle();
    write_vector_length(len);
    usable_cols.delete();
    for (int i = 0; i < int'(gen_eff); i++)
      if (gen_written[i]) usable_cols.push_back(i);
    n_loads = (gen_eff <= 8) ? int'(gen_eff) : 8;
    for (int k = 0; k < n_loads; k++)
      add_item(CMD_LOAD, (gen_eff <= 8) ? k : $urandom_range(0, int'(gen_eff) - 1),
               rand_value(), 1'($urandom_range(0, 1)));
  endtask

  // ---------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------
  localparam logic [VALUE_W-1:0] V_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] V_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  initial begin : main_proc
    logic [LENGTH_W-1:0] lengths[$];
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, at the reset length of 1024. Loads with tlast set must be
    // treated as plain loads.
    add_item(CMD_LOAD, 0, V_MAX, 1'b1);
    add_item(CMD_LOAD, 1, V_MIN, 1'b0);
    add_item(CMD_LOAD, DEPTH - 1, V_MIN, 1'b0);
    add_item(CMD_LOAD, 2, VALUE_W'(1), 1'b0);
    // Three large positive products: the sum saturates high.
    add_item(CMD_NONZERO, 0, V_MAX, 1'b0);
    add_item(CMD_NONZERO, 1, V_MIN, 1'b0);
    add_item(CMD_NONZERO, 1, V_MIN, 1'b1);
    // Three large negative products, one through the top column: saturates low.
    add_item(CMD_NONZERO, DEPTH - 1, V_MAX, 1'b0);
    add_item(CMD_NONZERO, 1, V_MAX, 1'b0);
    add_item(CMD_NONZERO, 1, V_MAX, 1'b1);
    // An empty row, then a close that flushes a partial row.
    add_item(CMD_CLOSE, 0, '0, 1'b1);
    add_item(CMD_NONZERO, 2, {VALUE_W{1'b1}}, 1'b0);
    add_item(CMD_CLOSE, DEPTH - 1, V_MAX, 1'b0);
    // The unused command produces nothing, even with tlast set.
    add_item(CMD_UNUSED, DEPTH - 1, V_MAX, 1'b1);
    // Sent only once every earlier row has come back.
    add_item(CMD_NONZERO, 0, '0, 1'b1, 1'b1);

    // Length 3 while the row counter sits above it; columns past the end
    // flag the row, and row numbers wrap at three.
    wait_idle();
    write_vector_length(LENGTH_W'(3));
    add_item(CMD_NONZERO, 3, VALUE_W'(1), 1'b1);
    add_item(CMD_NONZERO, 2, V_MAX, 1'b0);
    add_item(CMD_NONZERO, 1000, VALUE_W'(5), 1'b1);
    add_item(CMD_CLOSE, 0, '0, 1'b0);
    add_item(CMD_CLOSE, 0, '0, 1'b0);
    add_item(CMD_CLOSE, 0, '0, 1'b0);

    // Length zero behaves as one.
    wait_idle();
    write_vector_length('0);
    add_item(CMD_NONZERO, 0, V_MIN, 1'b1);
    add_item(CMD_NONZERO, 1, V_MAX, 1'b1);
    add_item(CMD_CLOSE, 0, '0, 1'b1);

    // A register value above the depth acts as 1024. Short rows keep this
    // phase going until the row number has passed 1023 and wrapped to zero.
    start_random_phase({LENGTH_W{1'b1}});
    add_random_rows(DEPTH - int'(row_model) + 40, 1'b1);

    lengths = '{LENGTH_W'(1), LENGTH_W'(2), LENGTH_W'(1024), LENGTH_W'(5), LENGTH_W'(37),
                LENGTH_W'(1023), LENGTH_W'(1025), LENGTH_W'(700),
                LENGTH_W'($urandom_range(1, 1024))};
    foreach (lengths[i]) begin
      start_random_phase(lengths[i]);
      add_random_rows(5, 1'b0);
    end

    wait_idle();
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Far beyond the slowest correct run, including the longest receiver stalls.
  initial begin : timeout_proc
    #2000000;
    $display("%0t: timeout with %0d rows still pending", $time, expected_rows.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
sv/csrspmv_pkg.sv
sv/csr_sparse_matrix_vector_multiply.sv
sv/csrspmv_checker.sv
tb/sv/tb_csr_sparse_matrix_vector_multiply.sv
